// ===== design/gcrf_pkg.sv =====
// ----------------------------------------------------------------------------
// gcrf_pkg
// Shared types, codes and helper functions of the geometry register file.
// ----------------------------------------------------------------------------
`default_nettype none

package gcrf_pkg;

    localparam int AW = 5;
    localparam int DW = 32;

    // command codes
    localparam logic [2:0] CMD_DWR   = 3'd0;
    localparam logic [2:0] CMD_DRD   = 3'd1;
    localparam logic [2:0] CMD_CWR   = 3'd2;
    localparam logic [2:0] CMD_CRD   = 3'd3;
    localparam logic [2:0] CMD_AVSZ3 = 3'd4;
    localparam logic [2:0] CMD_AVSZ4 = 3'd5;

    // register indexes
    localparam logic [AW-1:0] D_OTZ  = 5'd7;
    localparam logic [AW-1:0] D_IR1  = 5'd9;
    localparam logic [AW-1:0] D_IR2  = 5'd10;
    localparam logic [AW-1:0] D_IR3  = 5'd11;
    localparam logic [AW-1:0] D_SXY0 = 5'd12;
    localparam logic [AW-1:0] D_SXY1 = 5'd13;
    localparam logic [AW-1:0] D_SXY2 = 5'd14;
    localparam logic [AW-1:0] D_SXYP = 5'd15;
    localparam logic [AW-1:0] D_SZ0  = 5'd16;
    localparam logic [AW-1:0] D_SZ1  = 5'd17;
    localparam logic [AW-1:0] D_SZ2  = 5'd18;
    localparam logic [AW-1:0] D_SZ3  = 5'd19;
    localparam logic [AW-1:0] D_MAC0 = 5'd24;
    localparam logic [AW-1:0] D_IRGB = 5'd28;
    localparam logic [AW-1:0] D_LZCS = 5'd30;
    localparam logic [AW-1:0] D_LZCR = 5'd31;
    localparam logic [AW-1:0] C_ZSF3 = 5'd29;
    localparam logic [AW-1:0] C_ZSF4 = 5'd30;
    localparam logic [AW-1:0] C_FLAG = 5'd31;

    localparam logic [DW-1:0] FLAG_KEEP  = 32'h7ffff000;
    localparam logic [DW-1:0] FLAG_ERR   = 32'h7f87e000;
    localparam logic [DW-1:0] FLAG_MPOS  = 32'h80010000;
    localparam logic [DW-1:0] FLAG_MNEG  = 32'h80008000;
    localparam logic [DW-1:0] FLAG_OTZ   = 32'h80040000;
    localparam logic [DW-1:0] ERR_BIT    = 32'h80000000;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } seq_state_t;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        logic [DW-1:0] wdata;
        logic [AW-1:0] raddr;
    } mem_req_t;

    function automatic logic [DW-1:0] sext16(input logic [DW-1:0] v);
        sext16 = {{16{v[15]}}, v[15:0]};
    endfunction

    function automatic logic [DW-1:0] zext16(input logic [DW-1:0] v);
        zext16 = {16'h0000, v[15:0]};
    endfunction

    // leading zeros of one byte, 8 when zero
    function automatic logic [3:0] lz8(input logic [7:0] b);
        logic       hit;
        logic [3:0] n;
        hit = 1'b0;
        n   = 4'd0;
        for (int i = 7; i >= 0; i--) begin
            if (!hit && !b[i])
                n = n + 4'd1;
            else
                hit = 1'b1;
        end
        lz8 = n;
    endfunction

    function automatic logic [DW-1:0] data_rd_ext(input logic [AW-1:0] i,
                                                  input logic [DW-1:0] v);
        if (i inside {5'd1, 5'd3, 5'd5, 5'd8, 5'd9, 5'd10, 5'd11})
            data_rd_ext = sext16(v);
        else if (i inside {5'd7, [5'd16:5'd19]})
            data_rd_ext = zext16(v);
        else
            data_rd_ext = v;
    endfunction

    function automatic logic [DW-1:0] ctrl_wr_ext(input logic [AW-1:0] i,
                                                  input logic [DW-1:0] v);
        if (i inside {5'd4, 5'd12, 5'd20, 5'd26, 5'd27, 5'd29, 5'd30})
            ctrl_wr_ext = sext16(v);
        else if (i == C_FLAG)
            ctrl_wr_ext = (v & FLAG_KEEP) | (((v & FLAG_ERR) != '0) ? ERR_BIT : '0);
        else
            ctrl_wr_ext = v;
    endfunction

endpackage

`default_nettype wire

// ===== design/geometry_coprocessor_register_file.sv =====
// ----------------------------------------------------------------------------
// geometry_coprocessor_register_file
// Data/control register file of a geometry coprocessor with AVSZ3/AVSZ4.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Every
// transaction, writes included, answers with exactly one done pulse in the
// first cycle that busy is low again; read_data holds the read value with
// it, zero for non-reads. The receiver cannot stall, so results must be
// captured on the pulse. Busy time is set by the single RAM port of each
// bank, one access per cycle: plain writes and control writes are shortest,
// then reads, IRGB writes, SXYP writes, LZCS writes, AVSZ3/AVSZ4 longest.
// The next transaction may start in the cycle the done pulse is shown. Both
// banks read as zero after reset via per-entry valid bits; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module geometry_coprocessor_register_file (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [2:0]              cmd,
    input  wire logic [gcrf_pkg::AW-1:0] reg_index,
    input  wire logic [gcrf_pkg::DW-1:0] write_data,
    output logic                         done,
    output logic [gcrf_pkg::DW-1:0]      read_data
);
    import gcrf_pkg::*;

    mem_req_t      dreq;
    mem_req_t      creq;
    logic [DW-1:0] drdata;
    logic [DW-1:0] crdata;

    // data bank
    gcrf_ram u_dram (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rdata (drdata)
    );

    // control bank
    gcrf_ram u_cram (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (creq),
        .rdata (crdata)
    );

    // command sequencer
    gcrf_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .reg_index  (reg_index),
        .write_data (write_data),
        .dreq       (dreq),
        .creq       (creq),
        .drdata     (drdata),
        .crdata     (crdata),
        .done       (done),
        .read_data  (read_data)
    );

endmodule

`default_nettype wire

// ===== design/gcrf_ram.sv =====
// ----------------------------------------------------------------------------
// gcrf_ram
// 32 x 32 synchronous RAM, one write and one registered read per cycle.
// Per-entry valid bits make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module gcrf_ram (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire gcrf_pkg::mem_req_t req,
    output logic [gcrf_pkg::DW-1:0] rdata
);
    import gcrf_pkg::*;

    logic [DW-1:0]       mem [2**AW];
    logic [(2**AW)-1:0]  valid_reg;
    logic [DW-1:0]       rd_reg;
    logic                rvld_reg;

    always_ff @(posedge clk) begin
        if (req.we)
            mem[req.waddr] <= req.wdata;
        rd_reg <= mem[req.raddr];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= '0;
            rvld_reg  <= 1'b0;
        end
        else begin
            if (req.we)
                valid_reg[req.waddr] <= 1'b1;
            rvld_reg <= valid_reg[req.raddr];
        end
    end

    assign rdata = rvld_reg ? rd_reg : '0;

endmodule

`default_nettype wire

// ===== design/gcrf_seq.sv =====
// ----------------------------------------------------------------------------
// gcrf_seq
// Command sequencer: steps each transaction through reads and writes of the
// data and control RAMs, with the AVSZ multiply and leading-bit count.
// ----------------------------------------------------------------------------
`default_nettype none

module gcrf_seq (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [2:0]             cmd,
    input  wire logic [gcrf_pkg::AW-1:0] reg_index,
    input  wire logic [gcrf_pkg::DW-1:0] write_data,
    output gcrf_pkg::mem_req_t          dreq,
    output gcrf_pkg::mem_req_t          creq,
    input  wire logic [gcrf_pkg::DW-1:0] drdata,
    input  wire logic [gcrf_pkg::DW-1:0] crdata,
    output logic                        done,
    output logic [gcrf_pkg::DW-1:0]     read_data
);
    import gcrf_pkg::*;

    seq_state_t         state_reg, state_next;
    logic [2:0]         step_reg, step_next;
    logic [2:0]         cmd_reg;
    logic [AW-1:0]      idx_reg;
    logic [DW-1:0]      wdat_reg;
    logic [DW-1:0]      t0_reg, t0_next;
    logic [DW-1:0]      t1_reg, t1_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic               found_reg, found_next;
    logic [17:0]        acc_reg, acc_next;
    logic signed [15:0] scale_reg, scale_next;
    logic signed [34:0] prod_reg, prod_next;
    logic               done_reg, done_next;
    logic [DW-1:0]      rdout_reg, rdout_next;

    logic [DW-1:0]      lz_work;
    logic [7:0]         lz_byte;
    logic [3:0]         lz_n;
    logic [5:0]         cnt_base;
    logic               found_base;
    logic [15:0]        otz;
    logic [DW-1:0]      flag;
    logic signed [34:0] prod_c;
    logic               accept;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign prod_c = $signed({1'b0, acc_reg}) * scale_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk) begin
        if (accept) begin
            cmd_reg  <= cmd;
            idx_reg  <= reg_index;
            wdat_reg <= write_data;
        end
        t0_reg    <= t0_next;
        t1_reg    <= t1_next;
        cnt_reg   <= cnt_next;
        found_reg <= found_next;
        acc_reg   <= acc_next;
        scale_reg <= scale_next;
        prod_reg  <= prod_next;
        rdout_reg <= rdout_next;
    end

    // leading-bit count, one byte per step
    always_comb begin
        lz_work = wdat_reg[31] ? ~wdat_reg : wdat_reg;
        case (step_reg[1:0])
            2'd0:    lz_byte = lz_work[31:24];
            2'd1:    lz_byte = lz_work[23:16];
            2'd2:    lz_byte = lz_work[15:8];
            default: lz_byte = lz_work[7:0];
        endcase
        lz_n       = lz8(lz_byte);
        cnt_base   = (step_reg == 3'd0) ? 6'd0 : cnt_reg;
        found_base = (step_reg == 3'd0) ? 1'b0 : found_reg;
    end

    // AVSZ saturation and flags
    always_comb begin
        flag = '0;
        if (!prod_reg[34] && (prod_reg[33:31] != 3'b000))
            flag = FLAG_MPOS;
        else if (prod_reg[34] && (prod_reg[33:31] != 3'b111))
            flag = FLAG_MNEG;
        if (prod_reg[34]) begin
            otz  = 16'h0000;
            flag = flag | FLAG_OTZ;
        end
        else if (prod_reg[33:28] != '0) begin
            otz  = 16'hffff;
            flag = flag | FLAG_OTZ;
        end
        else begin
            otz = prod_reg[27:12];
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        t0_next    = t0_reg;
        t1_next    = t1_reg;
        cnt_next   = cnt_reg;
        found_next = found_reg;
        acc_next   = acc_reg;
        scale_next = scale_reg;
        prod_next  = prod_reg;
        done_next  = 1'b0;
        rdout_next = rdout_reg;
        dreq       = '0;
        creq       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    state_next = ST_RUN;
                    step_next  = '0;
                end
            end
            ST_RUN:
            begin
                step_next = step_reg + 3'd1;
                case (cmd_reg)
                    CMD_DWR:
                    begin
                        if (idx_reg == D_SXYP) begin
                            // FIFO push: SXY0 <- SXY1 <- SXY2 <- value
                            case (step_reg)
                                3'd0: dreq.raddr = D_SXY1;
                                3'd1:
                                begin
                                    dreq.raddr = D_SXY2;
                                    t0_next    = drdata;
                                end
                                3'd2:
                                begin
                                    t1_next    = drdata;
                                    dreq.we    = 1'b1;
                                    dreq.waddr = D_SXY0;
                                    dreq.wdata = t0_reg;
                                end
                                3'd3:
                                begin
                                    dreq.we    = 1'b1;
                                    dreq.waddr = D_SXY1;
                                    dreq.wdata = t1_reg;
                                end
                                default:
                                begin
                                    dreq.we    = 1'b1;
                                    dreq.waddr = D_SXY2;
                                    dreq.wdata = wdat_reg;
                                    state_next = ST_IDLE;
                                    done_next  = 1'b1;
                                    rdout_next = '0;
                                end
                            endcase
                        end
                        else if (idx_reg == D_IRGB) begin
                            dreq.we = 1'b1;
                            case (step_reg)
                                3'd0:
                                begin
                                    dreq.waddr = D_IR1;
                                    dreq.wdata = {20'h0, wdat_reg[4:0], 7'h00};
                                end
                                3'd1:
                                begin
                                    dreq.waddr = D_IR2;
                                    dreq.wdata = {20'h0, wdat_reg[9:5], 7'h00};
                                end
                                3'd2:
                                begin
                                    dreq.waddr = D_IR3;
                                    dreq.wdata = {20'h0, wdat_reg[14:10], 7'h00};
                                end
                                default:
                                begin
                                    dreq.waddr = D_IRGB;
                                    dreq.wdata = wdat_reg;
                                    state_next = ST_IDLE;
                                    done_next  = 1'b1;
                                    rdout_next = '0;
                                end
                            endcase
                        end
                        else if (idx_reg == D_LZCS) begin
                            if (step_reg < 3'd4) begin
                                found_next = found_base || (lz_byte != 8'h00);
                                cnt_next   = found_base ? cnt_base
                                                        : cnt_base + {2'b00, lz_n};
                            end
                            else if (step_reg == 3'd4) begin
                                dreq.we    = 1'b1;
                                dreq.waddr = D_LZCR;
                                dreq.wdata = {26'h0, cnt_reg};
                            end
                            else begin
                                dreq.we    = 1'b1;
                                dreq.waddr = D_LZCS;
                                dreq.wdata = wdat_reg;
                                state_next = ST_IDLE;
                                done_next  = 1'b1;
                                rdout_next = '0;
                            end
                        end
                        else begin
                            // LZCR is read-only
                            dreq.we    = (idx_reg != D_LZCR);
                            dreq.waddr = idx_reg;
                            dreq.wdata = wdat_reg;
                            state_next = ST_IDLE;
                            done_next  = 1'b1;
                            rdout_next = '0;
                        end
                    end
                    CMD_DRD:
                    begin
                        dreq.raddr = (idx_reg == D_SXYP) ? D_SXY2 : idx_reg;
                        if (step_reg != 3'd0) begin
                            state_next = ST_IDLE;
                            done_next  = 1'b1;
                            rdout_next = data_rd_ext(idx_reg, drdata);
                        end
                    end
                    CMD_CWR:
                    begin
                        creq.we    = 1'b1;
                        creq.waddr = idx_reg;
                        creq.wdata = ctrl_wr_ext(idx_reg, wdat_reg);
                        state_next = ST_IDLE;
                        done_next  = 1'b1;
                        rdout_next = '0;
                    end
                    CMD_CRD:
                    begin
                        creq.raddr = idx_reg;
                        if (step_reg != 3'd0) begin
                            state_next = ST_IDLE;
                            done_next  = 1'b1;
                            rdout_next = crdata;
                        end
                    end
                    CMD_AVSZ3, CMD_AVSZ4:
                    begin
                        case (step_reg)
                            3'd0:
                            begin
                                creq.raddr = (cmd_reg == CMD_AVSZ4) ? C_ZSF4 : C_ZSF3;
                                dreq.raddr = D_SZ0;
                            end
                            3'd1:
                            begin
                                scale_next = $signed(crdata[15:0]);
                                acc_next   = (cmd_reg == CMD_AVSZ4)
                                           ? {2'b00, drdata[15:0]} : '0;
                                dreq.raddr = D_SZ1;
                            end
                            3'd2:
                            begin
                                acc_next   = acc_reg + {2'b00, drdata[15:0]};
                                dreq.raddr = D_SZ2;
                            end
                            3'd3:
                            begin
                                acc_next   = acc_reg + {2'b00, drdata[15:0]};
                                dreq.raddr = D_SZ3;
                            end
                            3'd4:
                                acc_next   = acc_reg + {2'b00, drdata[15:0]};
                            3'd5:
                            begin
                                prod_next  = prod_c;
                                dreq.raddr = D_OTZ;
                            end
                            3'd6:
                            begin
                                t0_next    = drdata;
                                dreq.we    = 1'b1;
                                dreq.waddr = D_MAC0;
                                dreq.wdata = prod_reg[31:0];
                            end
                            default:
                            begin
                                dreq.we    = 1'b1;
                                dreq.waddr = D_OTZ;
                                dreq.wdata = {t0_reg[31:16], otz};
                                creq.we    = 1'b1;
                                creq.waddr = C_FLAG;
                                creq.wdata = flag;
                                state_next = ST_IDLE;
                                done_next  = 1'b1;
                                rdout_next = '0;
                            end
                        endcase
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                        done_next  = 1'b1;
                        rdout_next = '0;
                    end
                endcase
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign done      = done_reg;
    assign read_data = rdout_reg;

endmodule

`default_nettype wire

// ===== tb/gcrf_checker.sv =====
// ----------------------------------------------------------------------------
// gcrf_checker
// Watches accepted transactions and done pulses of the register file, keeps
// a shadow of both banks, and compares every read_data with its prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module gcrf_checker (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic                    busy,
    input  wire logic [2:0]              cmd,
    input  wire logic [gcrf_pkg::AW-1:0] reg_index,
    input  wire logic [gcrf_pkg::DW-1:0] write_data,
    input  wire logic                    done,
    input  wire logic [gcrf_pkg::DW-1:0] read_data,
    output int                           errors,
    output int                           pending
);
    import gcrf_pkg::*;

    logic [DW-1:0] shadow_data [32];
    logic [DW-1:0] shadow_ctrl [32];
    logic [DW-1:0] expected_reads [$];

    function automatic logic [DW-1:0] ext16(input logic [DW-1:0] v, input bit sgn);
        return sgn ? {{16{v[15]}}, v[15:0]} : {16'h0, v[15:0]};
    endfunction

    // count of leading bits equal to the sign bit
    function automatic logic [DW-1:0] sign_run(input logic [DW-1:0] v);
        int n;
        n = 0;
        if (v[31])
            v = ~v;
        while (n < 32 && !v[31 - n])
            n++;
        return n;
    endfunction

    task automatic apply_avsz(input bit four);
        logic signed [63:0] scale, sum, prod;
        logic [DW-1:0]      flag, q;
        logic [15:0]        otz;
        scale = $signed(ext16(shadow_ctrl[four ? C_ZSF4 : C_ZSF3], 1'b1));
        sum = shadow_data[D_SZ1][15:0] + shadow_data[D_SZ2][15:0]
            + shadow_data[D_SZ3][15:0];
        if (four)
            sum += shadow_data[D_SZ0][15:0];
        prod = sum * scale;
        shadow_data[D_MAC0] = prod[31:0];
        flag = '0;
        if (prod > 64'sh7fffffff)
            flag = FLAG_MPOS;
        else if (prod < -64'sh80000000)
            flag = FLAG_MNEG;
        q = prod[43:12];
        if (q[31]) begin
            otz = 16'h0;
            flag |= FLAG_OTZ;
        end else if (q >= 32'h10000) begin
            otz = 16'hffff;
            flag |= FLAG_OTZ;
        end else
            otz = q[15:0];
        shadow_data[D_OTZ][15:0] = otz;
        shadow_ctrl[C_FLAG] = flag;
    endtask

    task automatic predict_transaction(input logic [2:0] c, input logic [AW-1:0] i,
                                       input logic [DW-1:0] v);
        logic [DW-1:0] r;
        r = '0;
        case (c)
            CMD_DWR:
                if (i == D_SXYP) begin
                    shadow_data[D_SXY0] = shadow_data[D_SXY1];
                    shadow_data[D_SXY1] = shadow_data[D_SXY2];
                    shadow_data[D_SXY2] = v;
                end else if (i != D_LZCR) begin
                    if (i == D_IRGB) begin
                        shadow_data[D_IR1] = (v & 32'h1f) << 7;
                        shadow_data[D_IR2] = (v & 32'h3e0) << 2;
                        shadow_data[D_IR3] = (v & 32'h7c00) >> 3;
                    end
                    if (i == D_LZCS)
                        shadow_data[D_LZCR] = sign_run(v);
                    shadow_data[i] = v;
                end
            CMD_DRD:
                case (i)
                    5'd1, 5'd3, 5'd5, 5'd8, D_IR1, D_IR2, D_IR3:
                        r = ext16(shadow_data[i], 1'b1);
                    D_OTZ, D_SZ0, D_SZ1, D_SZ2, D_SZ3:
                        r = ext16(shadow_data[i], 1'b0);
                    D_SXYP: r = shadow_data[D_SXY2];
                    default: r = shadow_data[i];
                endcase
            CMD_CWR:
                case (i)
                    5'd4, 5'd12, 5'd20, 5'd26, 5'd27, C_ZSF3, C_ZSF4:
                        shadow_ctrl[i] = ext16(v, 1'b1);
                    C_FLAG:
                        shadow_ctrl[i] = (v & FLAG_KEEP) | ((v & FLAG_ERR) != 0 ? ERR_BIT : 0);
                    default: shadow_ctrl[i] = v;
                endcase
            CMD_CRD:   r = shadow_ctrl[i];
            CMD_AVSZ3: apply_avsz(1'b0);
            CMD_AVSZ4: apply_avsz(1'b1);
            default: ;
        endcase
        expected_reads.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            errors <= 0;
            pending <= 0;
            expected_reads.delete();
            for (int k = 0; k < 32; k++) begin
                shadow_data[k] = '0;
                shadow_ctrl[k] = '0;
            end
        end else begin
            if (done) begin
                if (expected_reads.size() == 0) begin
                    $error("unexpected done, read_data=%h", read_data);
                    errors <= errors + 1;
                end else if (expected_reads[0] !== read_data) begin
                    $error("read_data mismatch: expected %h actual %h",
                           expected_reads[0], read_data);
                    errors <= errors + 1;
                    void'(expected_reads.pop_front());
                end else
                    void'(expected_reads.pop_front());
            end
            if (start && !busy)
                predict_transaction(cmd, reg_index, write_data);
            pending <= expected_reads.size();
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_geometry_coprocessor_register_file.sv =====
// ----------------------------------------------------------------------------
// tb_geometry_coprocessor_register_file
// Directed then random command stream for the register file; the checker
// beside the block predicts and compares, this top gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_geometry_coprocessor_register_file;
    import gcrf_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic [2:0]    cmd;
    logic [AW-1:0] reg_index;
    logic [DW-1:0] write_data;
    wire           busy;
    wire           done;
    wire [DW-1:0]  read_data;
    int            errors;
    int            pending;
    int            cycles;

    geometry_coprocessor_register_file uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .reg_index(reg_index), .write_data(write_data), .done(done),
        .read_data(read_data)
    );

    gcrf_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .reg_index(reg_index), .write_data(write_data), .done(done),
        .read_data(read_data), .errors(errors), .pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // watchdog: a stuck busy or lost done ends the run
    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // One transaction: hold start until the edge where busy is low, then
    // either keep start high for the next one or drop it.
    task automatic issue(input logic [2:0] c, input logic [AW-1:0] i,
                         input logic [DW-1:0] v);
        start      <= 1'b1;
        cmd        <= c;
        reg_index  <= i;
        write_data <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic pause(input bit allow);
        int n;
        if (allow && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 8);
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Random data mostly, with all-zero, all-one and sign-edge values mixed in.
    function automatic logic [DW-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 32'h0000_8000 | ($urandom & 32'h7fff);
            3: return $urandom & 32'hffff;
            4: return $urandom >> $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_transaction(input bit allow_idle);
        logic [2:0]    c;
        logic [AW-1:0] i;
        int            sel;
        sel = $urandom_range(0, 99);
        i = 5'($urandom_range(0, 31));
        if (sel < 25) c = CMD_DWR;
        else if (sel < 45) c = CMD_DRD;
        else if (sel < 60) c = CMD_CWR;
        else if (sel < 72) c = CMD_CRD;
        else if (sel < 82) c = CMD_AVSZ3;
        else if (sel < 92) c = CMD_AVSZ4;
        else c = 3'($urandom_range(6, 7));
        // steer data writes and reads, and control writes, toward the side-effect and AVSZ-input registers
        if ((c == CMD_DWR || c == CMD_DRD) && $urandom_range(0, 1))
            i = 5'($urandom_range(15, 19)) | (($urandom_range(0, 2) == 0) ? 5'd28 : 5'd0);
        if (c == CMD_CWR && $urandom_range(0, 1))
            i = 5'($urandom_range(29, 31));
        issue(c, i, pick_value());
        pause(allow_idle);
    endtask

    initial begin
        rst_n      = 1'b0;
        start      = 1'b0;
        cmd        = CMD_DWR;
        reg_index  = '0;
        write_data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset reads, side effects, FLAG masking, AVSZ saturation, an unused command
        issue(CMD_DRD, 5'd0, '0);
        issue(CMD_CRD, C_FLAG, '0);
        issue(CMD_DWR, D_SXYP, 32'h1111_1111);
        issue(CMD_DWR, D_SXYP, 32'h2222_2222);
        issue(CMD_DWR, D_SXYP, 32'hffff_ffff);
        issue(CMD_DRD, D_SXYP, '0);
        issue(CMD_DRD, D_SXY0, '0);
        issue(CMD_DWR, D_IRGB, 32'hffff_ffff);
        issue(CMD_DRD, D_IR3, '0);
        issue(CMD_DWR, D_LZCS, 32'h0);
        issue(CMD_DRD, D_LZCR, '0);
        issue(CMD_DWR, D_LZCS, 32'hffff_ffff);
        issue(CMD_DRD, D_LZCR, '0);
        issue(CMD_DWR, D_LZCR, 32'h1234_5678);
        issue(CMD_CWR, C_FLAG, 32'hffff_ffff);
        issue(CMD_CRD, C_FLAG, '0);
        issue(CMD_DWR, D_SZ0, 32'hffff_ffff);
        issue(CMD_DWR, D_SZ1, 32'h0000_ffff);
        issue(CMD_DWR, D_SZ2, 32'h0000_ffff);
        issue(CMD_DWR, D_SZ3, 32'h0000_ffff);
        issue(CMD_CWR, C_ZSF3, 32'h0000_7fff);
        issue(CMD_CWR, C_ZSF4, 32'h0000_8000);
        issue(CMD_AVSZ3, '0, '0);
        issue(CMD_DRD, D_MAC0, '0);
        issue(CMD_AVSZ4, '0, '0);
        issue(CMD_CRD, C_FLAG, '0);
        issue(3'd7, '0, '0);

        // random with bursty idling, then back to back at the end
        repeat (900) random_transaction(1'b1);
        repeat (150) random_transaction(1'b0);
        start <= 1'b0;

        while (pending != 0 || busy)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
